FILE: rtl/aws_pkg.sv
// shared types, constants and helpers of the auxin weighted steering block
package aws_pkg;

  // fixed-point format and block constants
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] EPS_IDLE = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] EPS_NEAR = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [63:0] PRED_LIM = 64'd1 << 62;
  localparam logic [63:0] HI_LIM   = PRED_LIM >> (32 - FRAC_BITS);
  localparam logic [47:0] WSUM_MAX = '1;
  localparam logic [32:0] AVG_LIM  = 33'h1_0000_0000;
  localparam logic [35:0] LIM3_Q   = 36'd3 << FRAC_BITS;
  localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV5_SHIFT = 34;

  localparam logic [30:0] MAX_SPEED_RST = 31'd98304;
  localparam logic [31:0] COHESION_RST  = 32'd0;
  localparam logic [30:0] TIME_STEP_RST = 31'd65536;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_COHESION  = 2'd1,
    CFG_TIME_STEP = 2'd2
  } aws_cfg_idx_t;

  // input item modes
  typedef enum logic [1:0] {
    MODE_GOAL  = 2'd0,
    MODE_GROUP = 2'd1,
    MODE_AUXIN = 2'd2
  } aws_mode_t;

  // item classes after the front end
  typedef enum logic [1:0] {
    KIND_GOAL  = 2'd0,
    KIND_GROUP = 2'd1,
    KIND_AUX   = 2'd2
  } aws_kind_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               last_auxin;
  } aws_in_t;

  typedef struct packed {
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic               idle;
    logic               slowed;
  } aws_out_t;

  typedef struct packed {
    aws_kind_t        kind;
    logic [2:0][31:0] vec;
    logic             last;
  } aws_item_t;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [31:0] cohesion;
    logic [30:0] time_step;
  } aws_cfg_t;

  typedef enum logic [2:0] {
    VM_IDLE, VM_NORM, VM_SQ, VM_SQACC, VM_ROOT, VM_DONE
  } aws_vm_st_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_DONE
  } aws_dv_st_t;

  typedef enum logic [5:0] {
    B_IDLE, B_MAG_GO, B_MAG_WT, B_GDIV_GO, B_GDIV_WT,
    B_DOT_MUL, B_DOT_ACC, B_COS_GO, B_COS_WT, B_F_GO, B_F_WT,
    B_ACC, B_FV_MUL, B_FV_ACC,
    B_Q_GO, B_Q_WT, B_QM_MUL, B_QM_ACC,
    B_MM_GO, B_MM_WT, B_ACT_GO, B_ACT_WT,
    B_PH_MUL, B_PH_ACC, B_PL_MUL, B_PL_ACC,
    B_PM_GO, B_PM_WT, B_CAP_MUL, B_CAP,
    B_SP_MUL, B_SP_DIVGO, B_SP_WT, B_EMIT
  } aws_back_st_t;

  // magnitude of a two's complement word
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(32'd0 - v) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? 64'(64'd0 - v) : v;
  endfunction

endpackage

FILE: rtl/aws_queue.sv
// item queue between the front end and the back end
module aws_queue #(
  parameter int DEPTH = aws_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  aws_pkg::aws_item_t din,
  output logic              full,
  input  logic              pop,
  output aws_pkg::aws_item_t dout,
  output logic              empty
);
  import aws_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aws_item_t      mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_r + 1'b1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

FILE: rtl/aws_front.sv
// front end: takes input beats, classifies them and queues them
module aws_front (
  input  logic               start,
  output logic               busy,
  input  aws_pkg::aws_in_t   in_data,
  input  logic               q_full,
  output logic               push,
  output aws_pkg::aws_item_t item
);
  import aws_pkg::*;

  logic accept;

  assign busy   = q_full;
  assign accept = start && !busy;

  // classify; a mode with no meaning is dropped here
  always_comb begin
    item.vec  = {in_data.vec_z, in_data.vec_y, in_data.vec_x};
    item.last = 1'b0;
    item.kind = KIND_GOAL;
    push      = 1'b0;
    case (in_data.mode)
      MODE_GOAL: begin
        item.kind = KIND_GOAL;
        push      = accept;
      end
      MODE_GROUP: begin
        item.kind = KIND_GROUP;
        push      = accept;
      end
      MODE_AUXIN: begin
        item.kind = KIND_AUX;
        item.last = in_data.last_auxin;
        push      = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/aws_vmag.sv
// vector magnitude unit: range shift, serial squares, bit-serial square root
module aws_vmag (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [2:0][63:0] vin,
  output logic             done,
  output logic [63:0]      mag,
  output logic [31:0]      scaled,
  output logic [2:0][31:0] sv
);
  import aws_pkg::*;

  aws_vm_st_t       state_r, state_nxt;
  logic [2:0][63:0] a_r, a_nxt;
  logic [2:0]       neg_r, neg_nxt;
  logic [5:0]       k_r, k_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [63:0]      acc_r, acc_nxt, x_r, x_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [61:0]      sq_p_r;
  logic [63:0]      trial, sq_sum;
  logic [127:0]     wide;
  logic             too_big;

  assign too_big = (|a_r[0][63:31]) || (|a_r[1][63:31]) || (|a_r[2][63:31]);
  assign trial   = r_r + bit_r;
  assign sq_sum  = acc_r + {2'b00, sq_p_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    neg_nxt   = neg_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    r_nxt     = r_r;
    bit_nxt   = bit_r;
    done      = 1'b0;
    case (state_r)
      VM_IDLE: begin
        if (go) begin
          for (int i = 0; i < 3; i++) begin
            a_nxt[i]   = mag64(vin[i]);
            neg_nxt[i] = vin[i][63];
          end
          k_nxt     = '0;
          state_nxt = VM_NORM;
        end
      end
      VM_NORM: begin
        if (too_big) begin
          for (int i = 0; i < 3; i++) begin
            a_nxt[i] = a_r[i] >> 1;
          end
          k_nxt = 6'(k_r + 1'b1);
        end else begin
          idx_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = VM_SQ;
        end
      end
      VM_SQ: begin
        state_nxt = VM_SQACC;
      end
      VM_SQACC: begin
        acc_nxt = sq_sum;
        if (idx_r == 2'd2) begin
          x_nxt     = sq_sum;
          r_nxt     = '0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = VM_ROOT;
        end else begin
          idx_nxt   = 2'(idx_r + 1'b1);
          state_nxt = VM_SQ;
        end
      end
      VM_ROOT: begin
        if (x_r >= trial) begin
          x_nxt = x_r - trial;
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = VM_DONE;
        end
      end
      VM_DONE: begin
        done      = 1'b1;
        state_nxt = VM_IDLE;
      end
      default: begin
        state_nxt = VM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= VM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    neg_r  <= neg_nxt;
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    x_r    <= x_nxt;
    r_r    <= r_nxt;
    bit_r  <= bit_nxt;
    sq_p_r <= a_r[idx_r][30:0] * a_r[idx_r][30:0];
  end

  // results: root scaled back up, saturated
  always_comb begin
    wide   = {64'd0, r_r} << k_r;
    mag    = (|wide[127:64]) ? '1 : wide[63:0];
    scaled = r_r[31:0];
    for (int i = 0; i < 3; i++) begin
      sv[i] = neg_r[i] ? 32'(32'd0 - a_r[i][31:0]) : a_r[i][31:0];
    end
  end

endmodule

FILE: rtl/aws_divider.sv
// unsigned restoring divider, one quotient bit per cycle
module aws_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import aws_pkg::*;

  aws_dv_st_t  state_r, state_nxt;
  logic [64:0] rem_r, rem_nxt, rem_sh;
  logic [63:0] quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  assign rem_sh = {rem_r[63:0], quo_r[63]};
  assign quo    = quo_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    case (state_r)
      DV_IDLE: begin
        if (go) begin
          rem_nxt   = '0;
          quo_nxt   = num;
          den_nxt   = den;
          cnt_nxt   = '0;
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          quo_nxt = {quo_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        cnt_nxt = 6'(cnt_r + 1'b1);
        if (cnt_r == 6'd63) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        done      = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

FILE: rtl/aws_back.sv
// back end: weight accumulation and speed computation sequencer
module aws_back (
  input  logic               clk,
  input  logic               rst_n,
  input  aws_pkg::aws_cfg_t  cfg,
  input  logic               q_empty,
  input  aws_pkg::aws_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  output aws_pkg::aws_out_t  out_data
);
  import aws_pkg::*;

  aws_back_st_t     state_r, state_nxt;
  logic [1:0]       idx_r, idx_nxt;
  aws_item_t        cur_r, cur_nxt;
  logic [2:0][31:0] goal_r, goal_nxt, grp_r, grp_nxt;
  logic [47:0]      ws_r, ws_nxt;
  logic [2:0][63:0] wvs_r, wvs_nxt, m_r, m_nxt, pred_r, pred_nxt;
  logic [63:0]      mag_r, mag_nxt, dot_r, dot_nxt, num_r, num_nxt;
  logic [31:0]      f_r, f_nxt;
  logic [32:0]      aq_r, aq_nxt;
  logic [63:0]      mm_r, mm_nxt, act_r, act_nxt, pm_r, pm_nxt, hi_r, hi_nxt;
  logic [31:0]      msc_r, msc_nxt;
  logic [2:0][31:0] svm_r, svm_nxt, spd_r, spd_nxt;
  logic             slow_r, slow_nxt, idle_r, idle_nxt;
  logic [30:0]      s_r, s_nxt;
  logic             out_valid_r, out_valid_nxt;
  aws_out_t         out_data_r, out_data_nxt;

  // shared multiplier
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p_r;

  // units
  logic             vm_go, vm_done;
  logic [2:0][63:0] vm_in;
  logic [63:0]      vm_mag;
  logic [31:0]      vm_scaled;
  logic [2:0][31:0] vm_sv;
  logic             dv_go, dv_done;
  logic [63:0]      dv_num, dv_den, dv_q;

  // helpers
  logic [31:0]      v_sel, v_abs;
  logic             v_neg;
  logic [63:0]      m_abs, cos_mag, prod, tr, t_val, wvs_add;
  logic [64:0]      ws_sum, wvs_sum;
  logic [35:0]      lim3;
  logic             slow_now;
  logic [30:0]      cap;

  aws_vmag u_vmag (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (vm_go),
    .vin    (vm_in),
    .done   (vm_done),
    .mag    (vm_mag),
    .scaled (vm_scaled),
    .sv     (vm_sv)
  );

  aws_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dv_go),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_q)
  );

  assign v_sel = cur_r.vec[idx_r];
  assign v_neg = v_sel[31];
  assign v_abs = mag32(v_sel);
  assign m_abs = mag64(m_r[idx_r]);

  assign ws_sum  = {17'd0, ws_r} + {33'd0, f_r};
  assign wvs_add = v_neg ? 64'(64'd0 - mul_p_r) : mul_p_r;
  assign wvs_sum = {wvs_r[idx_r][63], wvs_r[idx_r]} + {wvs_add[63], wvs_add};
  assign cos_mag = (dv_q > ONE_Q) ? ONE_Q : dv_q;
  assign prod    = mul_p_r + (aq_r[32] ? 64'({cfg.max_speed, 32'd0}) : 64'd0);
  assign tr      = 64'(hi_r << (32 - FRAC_BITS)) + (mul_p_r >> FRAC_BITS);
  assign t_val   = (hi_r > HI_LIM) ? PRED_LIM : ((tr > PRED_LIM) ? PRED_LIM : tr);
  assign lim3    = LIM3_Q - {{4{cfg.cohesion[31]}}, cfg.cohesion};
  assign slow_now = (lim3[35] || (pm_r > 64'(lim3))) && (pm_r > act_r);
  assign cap     = slow_r ? 31'(mul_p_r >> DIV5_SHIFT) : cfg.max_speed;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    goal_nxt      = goal_r;
    grp_nxt       = grp_r;
    ws_nxt        = ws_r;
    wvs_nxt       = wvs_r;
    m_nxt         = m_r;
    pred_nxt      = pred_r;
    mag_nxt       = mag_r;
    dot_nxt       = dot_r;
    num_nxt       = num_r;
    f_nxt         = f_r;
    aq_nxt        = aq_r;
    mm_nxt        = mm_r;
    act_nxt       = act_r;
    pm_nxt        = pm_r;
    hi_nxt        = hi_r;
    msc_nxt       = msc_r;
    svm_nxt       = svm_r;
    spd_nxt       = spd_r;
    slow_nxt      = slow_r;
    idle_nxt      = idle_r;
    s_nxt         = s_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    vm_go         = 1'b0;
    vm_in         = '0;
    dv_go         = 1'b0;
    dv_num        = '0;
    dv_den        = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_GROUP) begin
            grp_nxt = q_item.vec;
          end else begin
            cur_nxt   = q_item;
            state_nxt = B_MAG_GO;
          end
        end
      end
      // magnitude of the carried vector
      B_MAG_GO: begin
        vm_go = 1'b1;
        for (int i = 0; i < 3; i++) begin
          vm_in[i] = {{32{cur_r.vec[i][31]}}, cur_r.vec[i]};
        end
        state_nxt = B_MAG_WT;
      end
      B_MAG_WT: begin
        if (vm_done) begin
          mag_nxt = vm_mag;
          idx_nxt = '0;
          if (cur_r.kind == KIND_GOAL) begin
            if (vm_mag == '0) begin
              goal_nxt  = '0;
              state_nxt = B_IDLE;
            end else begin
              state_nxt = B_GDIV_GO;
            end
          end else if (vm_mag < EPS_NEAR || vm_mag == '0) begin
            f_nxt     = '0;
            state_nxt = B_ACC;
          end else begin
            dot_nxt   = '0;
            state_nxt = B_DOT_MUL;
          end
        end
      end
      // unit goal direction, one component per division
      B_GDIV_GO: begin
        dv_go     = 1'b1;
        dv_num    = {32'd0, v_abs} << FRAC_BITS;
        dv_den    = mag_r;
        state_nxt = B_GDIV_WT;
      end
      B_GDIV_WT: begin
        if (dv_done) begin
          goal_nxt[idx_r] = v_neg ? 32'(32'd0 - dv_q[31:0]) : dv_q[31:0];
          if (idx_r == 2'd2) begin
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = 2'(idx_r + 1'b1);
            state_nxt = B_GDIV_GO;
          end
        end
      end
      // dot product with the goal direction
      B_DOT_MUL: begin
        mul_a     = v_abs;
        mul_b     = mag32(goal_r[idx_r]);
        state_nxt = B_DOT_ACC;
      end
      B_DOT_ACC: begin
        if (v_neg ^ goal_r[idx_r][31]) begin
          dot_nxt = dot_r - mul_p_r;
        end else begin
          dot_nxt = dot_r + mul_p_r;
        end
        if (idx_r == 2'd2) begin
          state_nxt = B_COS_GO;
        end else begin
          idx_nxt   = 2'(idx_r + 1'b1);
          state_nxt = B_DOT_MUL;
        end
      end
      // cosine, clamped, then the weight
      B_COS_GO: begin
        dv_go     = 1'b1;
        dv_num    = mag64(dot_r);
        dv_den    = mag_r;
        state_nxt = B_COS_WT;
      end
      B_COS_WT: begin
        if (dv_done) begin
          num_nxt   = 64'((dot_r[63] ? (ONE_Q - cos_mag) : (ONE_Q + cos_mag)) << FRAC_BITS);
          state_nxt = B_F_GO;
        end
      end
      B_F_GO: begin
        dv_go     = 1'b1;
        dv_num    = num_r;
        dv_den    = ONE_Q + mag_r;
        state_nxt = B_F_WT;
      end
      B_F_WT: begin
        if (dv_done) begin
          f_nxt     = dv_q[31:0];
          state_nxt = B_ACC;
        end
      end
      // saturating accumulation of the weight and weighted vector
      B_ACC: begin
        ws_nxt    = (ws_sum > {17'd0, WSUM_MAX}) ? WSUM_MAX : ws_sum[47:0];
        idx_nxt   = '0;
        state_nxt = B_FV_MUL;
      end
      B_FV_MUL: begin
        mul_a     = f_r;
        mul_b     = v_abs;
        state_nxt = B_FV_ACC;
      end
      B_FV_ACC: begin
        if (wvs_sum[64] != wvs_sum[63]) begin
          wvs_nxt[idx_r] = wvs_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          wvs_nxt[idx_r] = wvs_sum[63:0];
        end
        if (idx_r != 2'd2) begin
          idx_nxt   = 2'(idx_r + 1'b1);
          state_nxt = B_FV_MUL;
        end else if (cur_r.last) begin
          idx_nxt   = '0;
          state_nxt = B_Q_GO;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      // movement vector: average direction scaled by the maximum speed
      B_Q_GO: begin
        if (ws_r >= 48'(EPS_IDLE) && ws_r != '0) begin
          dv_go     = 1'b1;
          dv_num    = mag64(wvs_r[idx_r]);
          dv_den    = {16'd0, ws_r};
          state_nxt = B_Q_WT;
        end else begin
          m_nxt[idx_r] = '0;
          if (idx_r == 2'd2) begin
            state_nxt = B_MM_GO;
          end else begin
            idx_nxt = 2'(idx_r + 1'b1);
          end
        end
      end
      B_Q_WT: begin
        if (dv_done) begin
          aq_nxt    = (dv_q > 64'(AVG_LIM)) ? AVG_LIM : dv_q[32:0];
          state_nxt = B_QM_MUL;
        end
      end
      B_QM_MUL: begin
        mul_a     = aq_r[31:0];
        mul_b     = {1'b0, cfg.max_speed};
        state_nxt = B_QM_ACC;
      end
      B_QM_ACC: begin
        m_nxt[idx_r] = wvs_r[idx_r][63] ? 64'(64'd0 - (prod >> FRAC_BITS))
                                        : (prod >> FRAC_BITS);
        if (idx_r == 2'd2) begin
          state_nxt = B_MM_GO;
        end else begin
          idx_nxt   = 2'(idx_r + 1'b1);
          state_nxt = B_Q_GO;
        end
      end
      B_MM_GO: begin
        vm_go     = 1'b1;
        vm_in     = m_r;
        state_nxt = B_MM_WT;
      end
      B_MM_WT: begin
        if (vm_done) begin
          mm_nxt    = vm_mag;
          msc_nxt   = vm_scaled;
          svm_nxt   = vm_sv;
          state_nxt = B_ACT_GO;
        end
      end
      // group cohesion check: distance now and after one step
      B_ACT_GO: begin
        vm_go = 1'b1;
        for (int i = 0; i < 3; i++) begin
          vm_in[i] = {{32{grp_r[i][31]}}, grp_r[i]};
        end
        state_nxt = B_ACT_WT;
      end
      B_ACT_WT: begin
        if (vm_done) begin
          act_nxt   = vm_mag;
          idx_nxt   = '0;
          state_nxt = B_PH_MUL;
        end
      end
      B_PH_MUL: begin
        mul_a     = m_abs[63:32];
        mul_b     = {1'b0, cfg.time_step};
        state_nxt = B_PH_ACC;
      end
      B_PH_ACC: begin
        hi_nxt    = mul_p_r;
        state_nxt = B_PL_MUL;
      end
      B_PL_MUL: begin
        mul_a     = m_abs[31:0];
        mul_b     = {1'b0, cfg.time_step};
        state_nxt = B_PL_ACC;
      end
      B_PL_ACC: begin
        pred_nxt[idx_r] = {{32{grp_r[idx_r][31]}}, grp_r[idx_r]} +
                          (m_r[idx_r][63] ? 64'(64'd0 - t_val) : t_val);
        if (idx_r == 2'd2) begin
          state_nxt = B_PM_GO;
        end else begin
          idx_nxt   = 2'(idx_r + 1'b1);
          state_nxt = B_PH_MUL;
        end
      end
      B_PM_GO: begin
        vm_go     = 1'b1;
        vm_in     = pred_r;
        state_nxt = B_PM_WT;
      end
      B_PM_WT: begin
        if (vm_done) begin
          pm_nxt    = vm_mag;
          state_nxt = B_CAP_MUL;
        end
      end
      // speed limit, a fifth of it when the group check trips
      B_CAP_MUL: begin
        mul_a     = {1'b0, cfg.max_speed};
        mul_b     = DIV5_RECIP;
        slow_nxt  = slow_now;
        state_nxt = B_CAP;
      end
      B_CAP: begin
        s_nxt   = (mm_r < {33'd0, cap}) ? mm_r[30:0] : cap;
        idx_nxt = '0;
        if (mm_r <= EPS_IDLE || msc_r == '0) begin
          idle_nxt  = 1'b1;
          state_nxt = B_EMIT;
        end else begin
          idle_nxt  = 1'b0;
          state_nxt = B_SP_MUL;
        end
      end
      // rescale the direction to the limited length
      B_SP_MUL: begin
        mul_a     = mag32(svm_r[idx_r]);
        mul_b     = {1'b0, s_r};
        state_nxt = B_SP_DIVGO;
      end
      B_SP_DIVGO: begin
        dv_go     = 1'b1;
        dv_num    = mul_p_r;
        dv_den    = {32'd0, msc_r};
        state_nxt = B_SP_WT;
      end
      B_SP_WT: begin
        if (dv_done) begin
          if (svm_r[idx_r][31]) begin
            spd_nxt[idx_r] = (dv_q > 64'h8000_0000) ? 32'h8000_0000
                                                    : 32'(32'd0 - dv_q[31:0]);
          end else begin
            spd_nxt[idx_r] = (dv_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q[31:0];
          end
          if (idx_r == 2'd2) begin
            state_nxt = B_EMIT;
          end else begin
            idx_nxt   = 2'(idx_r + 1'b1);
            state_nxt = B_SP_MUL;
          end
        end
      end
      // result beat, sums cleared for the next agent
      B_EMIT: begin
        out_valid_nxt = 1'b1;
        if (idle_r) begin
          out_data_nxt = '{speed_x: '0, speed_y: '0, speed_z: '0, idle: 1'b1, slowed: 1'b0};
        end else begin
          out_data_nxt = '{speed_x: spd_r[0], speed_y: spd_r[1], speed_z: spd_r[2],
                           idle: 1'b0, slowed: slow_r};
        end
        ws_nxt    = '0;
        wvs_nxt   = '0;
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // control and agent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      goal_r      <= '0;
      grp_r       <= '0;
      ws_r        <= '0;
      wvs_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      goal_r      <= goal_nxt;
      grp_r       <= grp_nxt;
      ws_r        <= ws_nxt;
      wvs_r       <= wvs_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    m_r        <= m_nxt;
    pred_r     <= pred_nxt;
    mag_r      <= mag_nxt;
    dot_r      <= dot_nxt;
    num_r      <= num_nxt;
    f_r        <= f_nxt;
    aq_r       <= aq_nxt;
    mm_r       <= mm_nxt;
    act_r      <= act_nxt;
    pm_r       <= pm_nxt;
    hi_r       <= hi_nxt;
    msc_r      <= msc_nxt;
    svm_r      <= svm_nxt;
    spd_r      <= spd_nxt;
    slow_r     <= slow_nxt;
    idle_r     <= idle_nxt;
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
    mul_p_r    <= mul_a * mul_b;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/auxin_weighted_steering.sv
// top level of the auxin weighted steering block
//
// Channels: an input beat is taken when start is high and busy is low. A
// goal beat loads the unit goal direction, a group beat the offset from
// the group centre, an auxin beat adds its weight to the running sums; an
// auxin beat with last_auxin set also yields one result beat. Results come
// on out_data for exactly one cycle with out_valid high; the receiver takes
// every result and cannot stall, so nothing waits on it.
// Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready
// are high (cfg_ready is always high); write only while the block is idle.
// Sequencing: a small queue decouples the input from the sequencer, which
// works on one beat at a time. A group beat only loads the group offset;
// goal and auxin beats go through the shared one-bit-per-cycle divider and
// the vector magnitude unit, an auxin beat at the agent skipping the
// divisions, and a last auxin adds the speed computation.
// Reset: synchronous, active low; configuration registers go to their
// defaults, the goal, group offset and sums clear and the queue empties.
module auxin_weighted_steering #(
  parameter int QUEUE_DEPTH = aws_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  aws_pkg::aws_in_t  in_data,
  output logic              out_valid,
  output aws_pkg::aws_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import aws_pkg::*;

  aws_cfg_t  cfg_r, cfg_nxt;
  aws_item_t f_item, q_item;
  logic      q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SPEED: cfg_nxt.max_speed = cfg_data[30:0];
        CFG_COHESION:  cfg_nxt.cohesion  = cfg_data;
        CFG_TIME_STEP: cfg_nxt.time_step = cfg_data[30:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_speed: MAX_SPEED_RST, cohesion: COHESION_RST,
                 time_step: TIME_STEP_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  aws_front u_front (
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .push    (q_push),
    .item    (f_item)
  );

  aws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  aws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a result beat is never followed directly by another
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result beats");

  // an idle result carries zero speed and no slow flag
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.idle) |->
      (out_data.speed_x == '0 && out_data.speed_y == '0 &&
       out_data.speed_z == '0 && !out_data.slowed))
    else $error("idle result with non-zero speed");

  // the queue is empty straight after reset, so busy is low
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

endmodule

FILE: dv/auxin_weighted_steering_test.sv
// self-checking testbench of the auxin weighted steering block
`timescale 1ns / 100ps

module auxin_weighted_steering_test;
  import aws_pkg::*;

  localparam int      CYCLE_LIMIT  = 4_000_000;
  localparam int      DRAIN_CYCLES = 1200;
  localparam longint  ONE          = 64'sd1 << FRAC_BITS;
  localparam longint  NEAR_EPS     = ((64'sd1 << FRAC_BITS) + 50000) / 100000;
  localparam longint  IDLE_EPS     = ((64'sd1 << FRAC_BITS) + 5000) / 10000;
  localparam longint  WSUM_TOP     = (64'sd1 << 48) - 1;
  localparam longint  PRED_TOP     = 64'sd1 << 62;
  localparam longint  I64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint  I64_MIN      = 64'sh8000_0000_0000_0000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  aws_in_t  in_data = '0;
  logic     out_valid;
  aws_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  auxin_weighted_steering dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and configuration
  longint unsigned  p_max_speed, p_time_step, p_wsum;
  longint           p_cohesion;
  longint           p_goal [3];
  longint           p_group [3];
  longint           p_fvsum [3];

  aws_out_t speed_queue [$];
  int  fail_count = 0;
  int  result_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;

  function automatic longint unsigned absval(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > I64_MAX - b) return I64_MAX;
    if (b < 0 && a < I64_MIN - b) return I64_MIN;
    return a + b;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // length of a vector; parts shifted below 2^31 first, reduced copy returned too
  function automatic longint unsigned length3(input longint v [3], output longint rv [3],
                                              output longint unsigned rlen);
    longint unsigned a [3];
    longint unsigned acc, r, s;
    int k;
    acc = 0;
    k = 0;
    for (int i = 0; i < 3; i++) a[i] = absval(v[i]);
    while ((a[0] >> k) >= 64'h8000_0000 || (a[1] >> k) >= 64'h8000_0000 ||
           (a[2] >> k) >= 64'h8000_0000) k++;
    for (int i = 0; i < 3; i++) begin
      s = a[i] >> k;
      rv[i] = v[i] < 0 ? -longint'(s) : longint'(s);
      acc += s * s;
    end
    r = floor_root(acc);
    rlen = r;
    if (k > 0 && r > (64'hFFFF_FFFF_FFFF_FFFF >> k)) return 64'hFFFF_FFFF_FFFF_FFFF;
    return r << k;
  endfunction

  function automatic longint unsigned scale_step(longint unsigned a, longint unsigned b);
    longint unsigned hi, r;
    hi = (a >> 32) * b;
    if (hi > (PRED_TOP >> (32 - FRAC_BITS))) return PRED_TOP;
    r = (hi << (32 - FRAC_BITS)) + (((a & 64'hFFFF_FFFF) * b) >> FRAC_BITS);
    return r > PRED_TOP ? PRED_TOP : r;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic steer_reset();
    p_max_speed = 98304;
    p_cohesion = 0;
    p_time_step = 65536;
    p_wsum = 0;
    for (int i = 0; i < 3; i++) begin
      p_goal[i] = 0;
      p_group[i] = 0;
      p_fvsum[i] = 0;
    end
  endtask

  // work out the speed beat that an input beat causes, if any
  task automatic steer_predict(aws_in_t it);
    longint v [3], rv [3], m [3], pred [3], dummy [3];
    longint unsigned len, rl, mm, msc, act, pm, cap, s, f, q, aq, r, t;
    longint dotp, cosv, lim3, qs;
    logic slow;
    aws_out_t res;
    v[0] = longint'(it.vec_x);
    v[1] = longint'(it.vec_y);
    v[2] = longint'(it.vec_z);
    case (it.mode)
      MODE_GOAL: begin
        len = length3(v, rv, rl);
        for (int i = 0; i < 3; i++) begin
          q = len != 0 ? (absval(v[i]) << FRAC_BITS) / len : 0;
          p_goal[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
      end
      MODE_GROUP: for (int i = 0; i < 3; i++) p_group[i] = v[i];
      MODE_AUXIN: begin
        len = length3(v, rv, rl);
        f = 0;
        if (len >= NEAR_EPS && len != 0) begin
          dotp = 0;
          for (int i = 0; i < 3; i++) dotp += v[i] * p_goal[i];
          cosv = dotp / longint'(len);
          if (cosv > ONE) cosv = ONE;
          if (cosv < -ONE) cosv = -ONE;
          f = (64'(ONE + cosv) << FRAC_BITS) / (64'(ONE) + len);
        end
        p_wsum = (p_wsum + f > WSUM_TOP) ? WSUM_TOP : p_wsum + f;
        for (int i = 0; i < 3; i++) p_fvsum[i] = sat_sum(p_fvsum[i], longint'(f) * v[i]);
        if (it.last_auxin) begin
          for (int i = 0; i < 3; i++) begin
            m[i] = 0;
            if (p_wsum >= IDLE_EPS && p_wsum != 0) begin
              qs = p_fvsum[i] / longint'(p_wsum);
              aq = absval(qs);
              if (aq > (64'd1 << 32)) aq = 64'd1 << 32;
              r = (aq * p_max_speed) >> FRAC_BITS;
              m[i] = qs < 0 ? -longint'(r) : longint'(r);
            end
          end
          mm = length3(m, rv, msc);
          act = length3(p_group, pred, rl);
          for (int i = 0; i < 3; i++) begin
            t = scale_step(absval(m[i]), p_time_step);
            pred[i] = p_group[i] + (m[i] < 0 ? -longint'(t) : longint'(t));
          end
          pm = length3(pred, dummy, rl);
          lim3 = 3 * ONE - p_cohesion;
          slow = (lim3 < 0 || pm > 64'(lim3)) && pm > act;
          cap = slow ? p_max_speed / 5 : p_max_speed;
          s = mm < cap ? mm : cap;
          res = '0;
          if (mm <= IDLE_EPS || msc == 0) begin
            res.idle = 1'b1;
          end else begin
            res.speed_x = clip32(rv[0] < 0 ? -longint'(absval(rv[0]) * s / msc)
                                           : longint'(absval(rv[0]) * s / msc));
            res.speed_y = clip32(rv[1] < 0 ? -longint'(absval(rv[1]) * s / msc)
                                           : longint'(absval(rv[1]) * s / msc));
            res.speed_z = clip32(rv[2] < 0 ? -longint'(absval(rv[2]) * s / msc)
                                           : longint'(absval(rv[2]) * s / msc));
            res.slowed = slow;
          end
          speed_queue.insert(speed_queue.size(), res);
          p_wsum = 0;
          for (int i = 0; i < 3; i++) p_fvsum[i] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // result checking at the rising edge
  always @(posedge clk) begin
    aws_out_t exp_beat;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      result_count <= result_count + 1;
      if (speed_queue.size() == 0) begin
        $error("unexpected speed beat %h", out_data);
        fail_count++;
      end else begin
        exp_beat = speed_queue.pop_front();
        if (out_data.speed_x !== exp_beat.speed_x) begin
          $error("speed_x exp %0d got %0d", exp_beat.speed_x, out_data.speed_x);
          fail_count++;
        end
        if (out_data.speed_y !== exp_beat.speed_y) begin
          $error("speed_y exp %0d got %0d", exp_beat.speed_y, out_data.speed_y);
          fail_count++;
        end
        if (out_data.speed_z !== exp_beat.speed_z) begin
          $error("speed_z exp %0d got %0d", exp_beat.speed_z, out_data.speed_z);
          fail_count++;
        end
        if (out_data.idle !== exp_beat.idle) begin
          $error("idle exp %0b got %0b", exp_beat.idle, out_data.idle);
          fail_count++;
        end
        if (out_data.slowed !== exp_beat.slowed) begin
          $error("slowed exp %0b got %0b", exp_beat.slowed, out_data.slowed);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // one input beat, with a random gap in front; start stays high until the
  // next beat, a gap or a drain lowers it
  task automatic send_beat(aws_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    steer_predict(it);
    items_sent++;
    @(negedge clk);
  endtask

  // wait for every expected speed beat, then let the sequencer settle
  task automatic drain();
    start <= 1'b0;
    while (speed_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // cfg_valid stays high until the caller lowers it after the last write
  task automatic write_reg(aws_cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_SPEED: p_max_speed = val[30:0];
      CFG_COHESION:  p_cohesion = longint'(signed'(val));
      CFG_TIME_STEP: p_time_step = val[30:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic aws_in_t make_beat(aws_mode_t md, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic last);
    aws_in_t it;
    it.mode = md;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.last_auxin = last;
    return it;
  endfunction

  // random component: mostly a few units, sometimes tiny or huge
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(2, 0)) - 1);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(int'($urandom_range(20 << 16)) - (10 << 16));
    endcase
  endfunction

  // directed rows: beat plus typed expectation where it is obvious
  typedef struct {
    aws_in_t  beat;
    logic     known;
    aws_out_t speed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(aws_in_t b, logic known = 1'b0, aws_out_t sp = '0);
    dir_row_t r;
    r.beat = b;
    r.known = known;
    r.speed = sp;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    aws_out_t idle_beat;
    aws_out_t exp_known;
    int agents;
    int n_aux;
    steer_reset();
    idle_beat = '0;
    idle_beat.idle = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // after reset: lone auxin at the agent has zero weight, so idle
    add_row(make_beat(MODE_AUXIN, 0, 0, 0, 1), 1'b1, idle_beat);
    add_row(make_beat(MODE_AUXIN, 32'd0, 32'd0, 32'd0, 1), 1'b1, idle_beat);
    // below the near threshold, still idle
    add_row(make_beat(MODE_AUXIN, 32'd0, 32'd0, 32'd0, 1), 1'b1, idle_beat);
    // zero goal and an auxin, then a goal, a group and plain auxins
    add_row(make_beat(MODE_GOAL, 0, 0, 0, 0));
    add_row(make_beat(MODE_AUXIN, 1 << 16, 0, 0, 1));
    add_row(make_beat(MODE_GOAL, 5 << 16, 0, 0, 1));
    add_row(make_beat(MODE_GROUP, 0, 0, 0, 1));
    add_row(make_beat(MODE_AUXIN, 2 << 16, 1 << 16, 0, 0));
    add_row(make_beat(MODE_AUXIN, -(1 << 16), 3 << 16, 32'hFFFF_0000, 1));
    // auxin straight behind the goal: weight zero, idle
    add_row(make_beat(MODE_AUXIN, -(3 << 16), 0, 0, 1), 1'b1, idle_beat);
    // extremes of the fields
    add_row(make_beat(MODE_GOAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    add_row(make_beat(MODE_GROUP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
    add_row(make_beat(MODE_AUXIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    add_row(make_beat(MODE_AUXIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    add_row(make_beat(MODE_AUXIN, 32'd1, 32'd1, 32'd1, 0));
    add_row(make_beat(MODE_AUXIN, 32'hFFFF_FFFF, 32'd0, 32'd3, 1));
    // odd modes: mode 3 ignored, last on goal/group ignored
    add_row(make_beat(aws_mode_t'(2'd3), 32'h1234_5678, 32'hFFFF_FFFF, 32'd0, 1));
    add_row(make_beat(MODE_GROUP, 10 << 16, 0, 0, 1));
    add_row(make_beat(MODE_GOAL, 1 << 16, 1 << 16, 0, 0));
    add_row(make_beat(MODE_AUXIN, 4 << 16, 4 << 16, 0, 0));
    add_row(make_beat(MODE_AUXIN, 1 << 16, 2 << 16, 1 << 16, 1));

    send_idle_pct = 38;
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat);
      if (dir_rows[i].known) begin
        exp_known = speed_queue[speed_queue.size() - 1];
        if (exp_known !== dir_rows[i].speed) begin
          $error("row %0d: predictor gives %h, table %h", i, exp_known, dir_rows[i].speed);
          fail_count++;
        end
      end
    end
    // hold off until every result is back
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MAX_SPEED, 32'h7FFF_FFFF);
          write_reg(CFG_COHESION, 32'h8000_0000);
          write_reg(CFG_TIME_STEP, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(CFG_MAX_SPEED, 32'd0);
          write_reg(CFG_COHESION, 32'h7FFF_FFFF);
          write_reg(CFG_TIME_STEP, 32'd0);
        end
        2: begin
          write_reg(CFG_MAX_SPEED, 32'd98304);
          write_reg(CFG_COHESION, 32'd2 << 16);
          write_reg(CFG_TIME_STEP, 32'd65536);
        end
        default: begin
          write_reg(CFG_MAX_SPEED, {1'b0, 31'($urandom)} | ($urandom_range(1) << 31));
          write_reg(CFG_COHESION, $urandom);
          write_reg(CFG_TIME_STEP, $urandom);
        end
      endcase
      cfg_valid <= 1'b0;
      send_idle_pct = (ph < 2) ? 38 : (ph < 4 ? 60 : 0);
      agents = 0;
      while (agents < 24) begin
        if ($urandom_range(9) == 0) begin
          // noise: a random beat of any mode, mode 3 included
          send_beat(make_beat(aws_mode_t'(2'($urandom_range(3))), $urandom, $urandom,
                              $urandom, 1'($urandom)));
        end else begin
          if ($urandom_range(2) != 0)
            send_beat(make_beat(MODE_GOAL, rand_comp(), rand_comp(), rand_comp(),
                                1'($urandom)));
          if ($urandom_range(2) != 0)
            send_beat(make_beat(MODE_GROUP, rand_comp(), rand_comp(), rand_comp(),
                                1'($urandom)));
          n_aux = $urandom_range(4, 1);
          for (int k = 0; k < n_aux; k++)
            send_beat(make_beat(MODE_AUXIN, rand_comp(), rand_comp(), rand_comp(),
                                k == n_aux - 1));
          agents++;
        end
      end
      drain();
    end

    $display("sent %0d input beats, checked %0d speed beats", items_sent, result_count);
    $display("covered register extremes, odd modes, saturation and idle/slowed paths");
    if (fail_count == 0 && speed_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
